FILE: hw/rtl/smcsr_pkg.sv
package smcsr_pkg;

  localparam int unsigned MaxRows    = 64;
  localparam int unsigned MaxCols    = 64;
  localparam int unsigned MaxEntries = 1024;

  localparam int unsigned DimW   = 7;
  localparam int unsigned ValW   = 32;
  localparam int unsigned CntW   = $clog2(MaxEntries + 1);
  localparam int unsigned EidxW  = $clog2(MaxEntries);
  localparam int unsigned RowAw  = $clog2(MaxRows);
  localparam int unsigned ColAw  = $clog2(MaxCols);
  localparam int unsigned BmAw   = RowAw + ColAw;
  localparam int unsigned BmDepth = 1 << BmAw;
  localparam int unsigned ProdW  = 2 * DimW;
  localparam int unsigned CfgIdxW = 1;

  typedef enum logic [1:0] {
    CMD_READ     = 2'd0,
    CMD_WRITE    = 2'd1,
    CMD_REDEF    = 2'd2,
    CMD_CONTAINS = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_NUM_ROWS = 1'b0,
    REG_NUM_COLS = 1'b1
  } reg_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_MOVE,
    S_RD_A,
    S_RD_B,
    S_RD_C,
    S_DONE
  } state_e;

  typedef struct packed {
    logic [DimW-1:0]        row;
    logic [DimW-1:0]        col;
    logic signed [ValW-1:0] value;
  } entry_t;

  typedef struct packed {
    logic [CntW-1:0]        stored_count;
    status_e                status;
    logic                   hit;
    logic signed [ValW-1:0] read_value;
  } result_t;

endpackage

FILE: hw/rtl/sparse_matrix_csr_store_unit.sv
// Sparse matrix store with a default value, entries kept in a 1024-entry RAM.
// Read, write and contains scan the stored entries.
// Redefine scans the entries; when it must rebuild the store it scans them again
// and walks every cell through an occupancy RAM. One command is handled at a time.
// After reset the whole occupancy RAM is cleared before input is taken;
// reset leaves the store empty with default value zero and both dimensions zero.
module sparse_matrix_csr_store_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [47:0]                 s_axis_tdata,  // row, col, value
  input  logic [1:0]                  s_axis_tuser,  // cmd
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [47:0]                 m_axis_tdata,  // read_value, hit, status, stored_count
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [smcsr_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [smcsr_pkg::DimW-1:0]  cfg_data_i
);
  import smcsr_pkg::*;

  state_e state_q, state_d;

  logic [DimW-1:0] rows_q, rows_d, cols_q, cols_d;
  logic [CntW-1:0] count_q, count_d;
  logic signed [ValW-1:0] dflt_q, dflt_d;

  cmd_e cmd_q, cmd_d;
  logic [DimW-1:0] row_q, row_d, col_q, col_d;
  logic signed [ValW-1:0] val_q, val_d;

  logic [CntW-1:0]  idx_q, idx_d;
  logic             pend_q, pend_d;
  logic [EidxW-1:0] pidx_q, pidx_d;
  logic [EidxW-1:0] ppos_q, ppos_d;
  logic [CntW-1:0]  drops_q, drops_d;
  logic [CntW-1:0]  w_q, w_d;
  logic [DimW-1:0]  cr_q, cr_d, cc_q, cc_d;
  logic [DimW-1:0]  pcr_q, pcr_d, pcc_q, pcc_d;
  logic             cpend_q, cpend_d;
  logic [BmAw:0]    clr_q, clr_d;

  result_t res_q, res_d;
  logic    out_valid_q, out_valid_d;
  result_t out_q, out_d;

  entry_t           mem [MaxEntries];
  entry_t           mem_rdata_q;
  logic [EidxW-1:0] mem_raddr, mem_waddr;
  logic             mem_we;
  entry_t           mem_wdata;

  logic             bm [BmDepth];
  logic             bm_rdata_q;
  logic [BmAw-1:0]  bm_raddr, bm_waddr;
  logic             bm_we, bm_wdata;

  logic s_fire, cfg_fire, out_free, scan_end, pos_match, val_match, cissue, cell_end;
  logic in_range;
  logic [DimW-1:0] in_row, in_col, row_m1, col_m1;
  logic signed [ValW-1:0] in_val;
  logic [ProdW-1:0] prod;
  logic [CntW-1:0] count_m1;

  assign in_row = s_axis_tdata[DimW-1:0];
  assign in_col = s_axis_tdata[2*DimW-1:DimW];
  assign in_val = s_axis_tdata[2*DimW+ValW-1:2*DimW];

  assign s_axis_tready = (state_q == S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;
  assign cfg_fire      = cfg_valid_i;
  assign out_free      = !out_valid_q || m_axis_tready;

  assign in_range = (in_row != '0) && (in_row <= rows_q) && (in_col != '0) && (in_col <= cols_q);
  assign scan_end  = !pend_q && (idx_q > count_q);
  assign pos_match = (mem_rdata_q.row == row_q) && (mem_rdata_q.col == col_q);
  assign val_match = (mem_rdata_q.value == val_q);
  assign cissue    = (cr_q < rows_q) && (cols_q != '0);
  assign cell_end  = !cpend_q && !cissue;
  assign prod      = ProdW'(rows_q) * ProdW'(cols_q);
  assign count_m1  = count_q - CntW'(1);
  assign row_m1    = mem_rdata_q.row - DimW'(1);
  assign col_m1    = mem_rdata_q.col - DimW'(1);

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(48 - $bits(result_t)){1'b0}}, out_q};

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_q == (BmAw+1)'(BmDepth - 1)) state_d = S_IDLE;
      S_IDLE: begin
        if (s_fire) begin
          unique case (cmd_e'(s_axis_tuser))
            CMD_READ, CMD_WRITE: state_d = in_range ? S_SCAN : S_DONE;
            CMD_REDEF:           state_d = S_RD_A;
            default:             state_d = S_SCAN;
          endcase
        end
      end
      S_SCAN: begin
        if (cmd_q == CMD_CONTAINS) begin
          if ((pend_q && val_match) || scan_end) state_d = S_DONE;
        end else if (pend_q && pos_match) begin
          state_d = (cmd_q == CMD_WRITE && val_q == dflt_q) ? S_MOVE : S_DONE;
        end else if (scan_end) begin
          state_d = S_DONE;
        end
      end
      S_MOVE: state_d = S_DONE;
      S_RD_A: begin
        if (scan_end) begin
          if (count_q == '0 || drops_q == '0 ||
              (ProdW+1)'(prod) > (ProdW+1)'(MaxEntries) + (ProdW+1)'(drops_q)) begin
            state_d = S_DONE;
          end else begin
            state_d = S_RD_B;
          end
        end
      end
      S_RD_B: if (scan_end) state_d = S_RD_C;
      S_RD_C: if (cell_end) state_d = S_DONE;
      S_DONE: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    rows_d = rows_q; cols_d = cols_q; count_d = count_q; dflt_d = dflt_q;
    cmd_d = cmd_q; row_d = row_q; col_d = col_q; val_d = val_q;
    idx_d = idx_q; pend_d = pend_q; pidx_d = pidx_q; ppos_d = ppos_q;
    drops_d = drops_q; w_d = w_q; cr_d = cr_q; cc_d = cc_q;
    pcr_d = pcr_q; pcc_d = pcc_q; cpend_d = cpend_q; clr_d = clr_q;
    res_d = res_q;
    mem_raddr = idx_q[EidxW-1:0];
    mem_we = 1'b0; mem_waddr = w_q[EidxW-1:0]; mem_wdata = mem_rdata_q;
    bm_raddr = {cr_q[RowAw-1:0], cc_q[ColAw-1:0]};
    bm_we = 1'b0; bm_waddr = {row_m1[RowAw-1:0], col_m1[ColAw-1:0]}; bm_wdata = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_d = out_q;

    if (state_q == S_SCAN || state_q == S_RD_A || state_q == S_RD_B) begin
      idx_d  = idx_q + CntW'(1);
      pend_d = idx_q < count_q;
      pidx_d = idx_q[EidxW-1:0];
    end

    unique case (state_q)
      S_CLEAR: begin
        bm_we = 1'b1;
        bm_waddr = clr_q[BmAw-1:0];
        clr_d = clr_q + (BmAw+1)'(1);
      end
      S_IDLE: begin
        if (s_fire) begin
          cmd_d = cmd_e'(s_axis_tuser);
          row_d = in_row; col_d = in_col; val_d = in_val;
          idx_d = '0; pend_d = 1'b0; drops_d = '0;
          res_d = '{stored_count: count_q, status: ST_RANGE, hit: 1'b0, read_value: '0};
        end
      end
      S_SCAN: begin
        if (cmd_q == CMD_CONTAINS) begin
          res_d = '{stored_count: count_q, status: ST_OK, hit: pend_q && val_match,
                    read_value: '0};
        end else if (pend_q && pos_match) begin
          res_d = '{stored_count: count_q, status: ST_OK, hit: 1'b1, read_value: '0};
          if (cmd_q == CMD_READ) begin
            res_d.read_value = mem_rdata_q.value;
          end else if (val_q == dflt_q) begin
            mem_raddr = count_m1[EidxW-1:0];
            ppos_d = pidx_q;
          end else begin
            mem_we = 1'b1;
            mem_waddr = pidx_q;
            mem_wdata = '{row: row_q, col: col_q, value: val_q};
          end
        end else if (scan_end) begin
          res_d = '{stored_count: count_q, status: ST_OK, hit: 1'b0, read_value: '0};
          if (cmd_q == CMD_READ) begin
            res_d.read_value = dflt_q;
          end else if (val_q != dflt_q) begin
            if (count_q >= CntW'(MaxEntries)) begin
              res_d.status = ST_FULL;
            end else begin
              mem_we = 1'b1;
              mem_waddr = count_q[EidxW-1:0];
              mem_wdata = '{row: row_q, col: col_q, value: val_q};
              count_d = count_q + CntW'(1);
              res_d.stored_count = count_q + CntW'(1);
            end
          end
        end
      end
      S_MOVE: begin
        mem_we = 1'b1;
        mem_waddr = ppos_q;
        count_d = count_m1;
        res_d = '{stored_count: count_m1, status: ST_OK, hit: 1'b1, read_value: '0};
      end
      S_RD_A: begin
        if (pend_q && val_match) drops_d = drops_q + CntW'(1);
        if (scan_end) begin
          res_d = '{stored_count: count_q, status: ST_OK, hit: 1'b0, read_value: '0};
          if (count_q == '0 || drops_q == '0) begin
            dflt_d = val_q;
          end else if ((ProdW+1)'(prod) >
                       (ProdW+1)'(MaxEntries) + (ProdW+1)'(drops_q)) begin
            res_d.status = ST_FULL;
          end else begin
            idx_d = '0; pend_d = 1'b0; w_d = '0;
          end
        end
      end
      S_RD_B: begin
        if (pend_q) begin
          bm_we = 1'b1;
          bm_wdata = 1'b1;
          if (!val_match) begin
            mem_we = 1'b1;
            w_d = w_q + CntW'(1);
          end
        end
        if (scan_end) begin
          cr_d = '0; cc_d = '0; cpend_d = 1'b0;
        end
      end
      S_RD_C: begin
        cpend_d = cissue;
        if (cissue) begin
          pcr_d = cr_q; pcc_d = cc_q;
          if (cc_q + DimW'(1) == cols_q) begin
            cc_d = '0;
            cr_d = cr_q + DimW'(1);
          end else begin
            cc_d = cc_q + DimW'(1);
          end
        end
        if (cpend_q) begin
          bm_we = 1'b1;
          bm_waddr = {pcr_q[RowAw-1:0], pcc_q[ColAw-1:0]};
          if (!bm_rdata_q && dflt_q != val_q) begin
            mem_we = 1'b1;
            mem_wdata = '{row: pcr_q + DimW'(1), col: pcc_q + DimW'(1), value: dflt_q};
            w_d = w_q + CntW'(1);
          end
        end
        if (cell_end) begin
          count_d = w_q;
          dflt_d = val_q;
          res_d = '{stored_count: w_q, status: ST_OK, hit: 1'b0, read_value: '0};
        end
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d = res_q;
        end
      end
      default: ;
    endcase

    if (cfg_fire) begin
      unique case (reg_e'(cfg_index_i))
        REG_NUM_ROWS: rows_d = (cfg_data_i > DimW'(MaxRows)) ? DimW'(MaxRows) : cfg_data_i;
        REG_NUM_COLS: cols_d = (cfg_data_i > DimW'(MaxCols)) ? DimW'(MaxCols) : cfg_data_i;
        default: ;
      endcase
      count_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (bm_we) bm[bm_waddr] <= bm_wdata;
    bm_rdata_q <= bm[bm_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      rows_q <= '0; cols_q <= '0; count_q <= '0; dflt_q <= '0;
      idx_q <= '0; pend_q <= 1'b0; cpend_q <= 1'b0; clr_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rows_q <= rows_d; cols_q <= cols_d; count_q <= count_d; dflt_q <= dflt_d;
      idx_q <= idx_d; pend_q <= pend_d; cpend_q <= cpend_d; clr_q <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; row_q <= row_d; col_q <= col_d; val_q <= val_d;
    pidx_q <= pidx_d; ppos_q <= ppos_d; drops_q <= drops_d; w_q <= w_d;
    cr_q <= cr_d; cc_q <= cc_d; pcr_q <= pcr_d; pcc_q <= pcc_d;
    res_q <= res_d; out_q <= out_d;
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(MaxEntries)) else $error("stored count exceeds capacity");
  a_no_input_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> !s_axis_tready) else $error("input taken during clear");
  a_compact_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_RD_B |-> w_q <= idx_q) else $error("compaction overtook scan");
`endif

endmodule

FILE: test/sparse_matrix_csr_store_unit_tb.sv
`timescale 1ns / 1ps

module sparse_matrix_csr_store_unit_tb;
  import smcsr_pkg::*;

  localparam int unsigned CycleLimit = 6000000;

  typedef enum logic {ROW_CFG, ROW_CMD} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    reg_e        regsel;
    cmd_e        cmd;
    logic [6:0]  row;
    logic [6:0]  col;
    logic [31:0] value;
    bit          typed;
    result_t     exp;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [47:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [DimW-1:0]    cfg_data_i;

  int unsigned csr_row_start [0:MaxRows];
  int unsigned csr_col [MaxEntries];
  int unsigned csr_value [MaxEntries];
  int unsigned tmp_col [MaxEntries];
  int unsigned tmp_value [MaxEntries];
  int unsigned csr_count;
  int unsigned csr_default;
  int unsigned csr_rows;
  int unsigned csr_cols;

  result_t     pending_results[$];
  stim_row_t   directed_rows[$];
  int unsigned error_count;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;

  sparse_matrix_csr_store_unit u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  function automatic void csr_empty();
    for (int i = 0; i <= MaxRows; i++) csr_row_start[i] = 1;
    csr_count = 0;
  endfunction

  function automatic int csr_find(int unsigned r, int unsigned c);
    int unsigned p;
    int unsigned e;
    p = csr_row_start[r-1] - 1;
    e = csr_row_start[r] - 1;
    for (; p < e && p < MaxEntries; p++) begin
      if (csr_col[p] == c) return int'(p);
    end
    return -1;
  endfunction

  function automatic bit csr_holds(int unsigned v);
    for (int unsigned i = 0; i < csr_count; i++) begin
      if (csr_value[i] == v) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic status_e csr_redefine(int unsigned nv);
    int unsigned drops;
    int unsigned n;
    int unsigned first;
    int p;
    longint unsigned total;
    drops = 0;
    if (csr_count == 0 || !csr_holds(nv)) begin
      csr_default = nv;
      return ST_OK;
    end
    for (int unsigned i = 0; i < csr_count; i++) begin
      if (csr_value[i] == nv) drops++;
    end
    total = longint'(csr_count) - drops + (longint'(csr_rows) * csr_cols - csr_count);
    if (total > MaxEntries) return ST_FULL;
    n = 0;
    for (int unsigned r = 1; r <= csr_rows; r++) begin
      first = n;
      for (int unsigned c = 1; c <= csr_cols; c++) begin
        p = csr_find(r, c);
        if (p >= 0) begin
          if (csr_value[p] != nv && n < MaxEntries) begin
            tmp_col[n] = c;
            tmp_value[n] = csr_value[p];
            n++;
          end
        end else if (csr_default != nv && n < MaxEntries) begin
          tmp_col[n] = c;
          tmp_value[n] = csr_default;
          n++;
        end
      end
      csr_row_start[r-1] = first + 1;
    end
    for (int unsigned i = csr_rows; i <= MaxRows; i++) csr_row_start[i] = n + 1;
    for (int unsigned i = 0; i < n; i++) begin
      csr_col[i] = tmp_col[i];
      csr_value[i] = tmp_value[i];
    end
    csr_count = n;
    csr_default = nv;
    return ST_OK;
  endfunction

  function automatic result_t csr_apply_cmd(cmd_e cmd, int unsigned r, int unsigned c,
                                            int unsigned v);
    result_t res;
    int p;
    int unsigned q;
    res = '0;
    res.status = ST_OK;
    if (cmd == CMD_READ || cmd == CMD_WRITE) begin
      if (r < 1 || r > csr_rows || c < 1 || c > csr_cols) begin
        res.status = ST_RANGE;
      end else begin
        p = csr_find(r, c);
        if (cmd == CMD_READ) begin
          res.hit = (p >= 0);
          res.read_value = (p >= 0) ? csr_value[p] : csr_default;
        end else if (p >= 0) begin
          res.hit = 1'b1;
          csr_value[p] = v;
          if (v == csr_default) begin
            for (q = p; q + 1 < csr_count; q++) begin
              csr_col[q] = csr_col[q+1];
              csr_value[q] = csr_value[q+1];
            end
            for (q = r; q <= csr_rows; q++) csr_row_start[q]--;
            csr_count--;
          end
        end else if (v != csr_default) begin
          if (csr_count >= MaxEntries) begin
            res.status = ST_FULL;
          end else begin
            p = csr_row_start[r-1] - 1;
            for (q = csr_count; q > p; q--) begin
              csr_col[q] = csr_col[q-1];
              csr_value[q] = csr_value[q-1];
            end
            csr_col[p] = c;
            csr_value[p] = v;
            for (q = r; q <= csr_rows; q++) csr_row_start[q]++;
            csr_count++;
          end
        end
      end
    end else if (cmd == CMD_REDEF) begin
      res.status = csr_redefine(v);
    end else begin
      res.hit = csr_holds(v);
    end
    res.stored_count = csr_count[CntW-1:0];
    return res;
  endfunction

  function automatic result_t mk_result(logic [31:0] rv, logic hit, status_e st,
                                        int unsigned cnt);
    result_t res;
    res.read_value = rv;
    res.hit = hit;
    res.status = st;
    res.stored_count = cnt[CntW-1:0];
    return res;
  endfunction

  task automatic write_register(reg_e regsel, logic [6:0] data);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= regsel;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    if (regsel == REG_NUM_ROWS) csr_rows = (data > MaxRows) ? MaxRows : data;
    else csr_cols = (data > MaxCols) ? MaxCols : data;
    csr_empty();
    @(posedge clk_i);
  endtask

  task automatic send_cmd(cmd_e cmd, logic [6:0] r, logic [6:0] c, logic [31:0] v,
                          bit typed, result_t exp);
    result_t pred;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {2'b00, v, c, r};
    s_axis_tuser <= cmd;
    do @(posedge clk_i); while (!s_axis_tready);
    pred = csr_apply_cmd(cmd, r, c, v);
    pending_results.push_back(typed ? exp : pred);
  endtask

  task automatic send_checked(cmd_e cmd, logic [6:0] r, logic [6:0] c, logic [31:0] v);
    send_cmd(cmd, r, c, v, 1'b0, '0);
  endtask

  task automatic add_cfg(reg_e regsel, logic [6:0] data);
    stim_row_t s;
    s = '{ROW_CFG, regsel, CMD_READ, 7'd0, 7'd0, {25'd0, data}, 1'b0, '0};
    directed_rows.push_back(s);
  endtask

  task automatic add_cmd(cmd_e cmd, logic [6:0] r, logic [6:0] c, logic [31:0] v,
                         bit typed, result_t exp);
    stim_row_t s;
    s = '{ROW_CMD, REG_NUM_ROWS, cmd, r, c, v, typed, exp};
    directed_rows.push_back(s);
  endtask

  task automatic random_item();
    cmd_e cmd;
    logic [6:0] r;
    logic [6:0] c;
    logic [31:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2:    cmd = CMD_READ;
      3, 4, 5, 6: cmd = CMD_WRITE;
      7:          cmd = CMD_REDEF;
      default:    cmd = CMD_CONTAINS;
    endcase
    if (csr_rows > 0 && $urandom_range(0, 99) < 90) r = $urandom_range(1, csr_rows);
    else r = $urandom_range(0, 127);
    if (csr_cols > 0 && $urandom_range(0, 99) < 90) c = $urandom_range(1, csr_cols);
    else c = $urandom_range(0, 127);
    if ($urandom_range(0, 99) < 80) v = $signed($urandom_range(0, 4)) - 2;
    else v = $urandom;
    send_checked(cmd, r, c, v);
  endtask

  task automatic random_dims();
    logic [6:0] r;
    logic [6:0] c;
    case ($urandom_range(0, 9))
      0:       begin r = $urandom_range(0, 127); c = $urandom_range(1, 6); end
      1:       begin r = $urandom_range(1, 6); c = $urandom_range(65, 127); end
      2:       begin r = 7'd64; c = $urandom_range(0, 4); end
      default: begin r = $urandom_range(1, 8); c = $urandom_range(1, 8); end
    endcase
    write_register(REG_NUM_ROWS, r);
    write_register(REG_NUM_COLS, c);
  endtask

  task automatic random_phase(int unsigned n_items);
    for (int unsigned i = 0; i < n_items; i++) begin
      if (i % 40 == 0) random_dims();
      if (i == n_items / 2) begin
        while (pending_results.size() > 0) begin
          s_axis_tvalid <= 1'b0;
          @(posedge clk_i);
        end
      end
      random_item();
    end
  endtask

  always @(posedge clk_i) begin
    if ($urandom_range(0, 99) < recv_idle_pct) m_axis_tready <= 1'b0;
    else m_axis_tready <= 1'b1;
  end

  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[45:0];
      if (pending_results.size() == 0) begin
        $error("result transfer with no expectation waiting: %h", m_axis_tdata);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.read_value !== want.read_value) begin
          $error("read_value expected %0d got %0d", want.read_value, got.read_value);
          error_count++;
        end
        if (got.hit !== want.hit) begin
          $error("hit expected %0d got %0d", want.hit, got.hit);
          error_count++;
        end
        if (got.status !== want.status) begin
          $error("status expected %0d got %0d", want.status, got.status);
          error_count++;
        end
        if (got.stored_count !== want.stored_count) begin
          $error("stored_count expected %0d got %0d", want.stored_count, got.stored_count);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    stim_row_t s;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    m_axis_tready = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = REG_NUM_ROWS;
    cfg_data_i = '0;
    error_count = 0;
    cycle_count = 0;
    send_idle_pct = 37;
    recv_idle_pct = 49;
    csr_rows = 0;
    csr_cols = 0;
    csr_default = 0;
    for (int i = 0; i < MaxEntries; i++) begin
      csr_col[i] = 0;
      csr_value[i] = 0;
    end
    csr_empty();

    add_cmd(CMD_READ, 7'd1, 7'd1, 32'd0, 1'b1, mk_result(32'd0, 1'b0, ST_RANGE, 0));
    add_cmd(CMD_CONTAINS, 7'd0, 7'd0, 32'd0, 1'b1, mk_result(32'd0, 1'b0, ST_OK, 0));
    add_cfg(REG_NUM_ROWS, 7'd127);
    add_cfg(REG_NUM_COLS, 7'd64);
    add_cmd(CMD_WRITE, 7'd64, 7'd64, 32'h7fffffff, 1'b0, '0);
    add_cmd(CMD_READ, 7'd64, 7'd64, 32'd0, 1'b1,
            mk_result(32'h7fffffff, 1'b1, ST_OK, 1));
    add_cmd(CMD_WRITE, 7'd64, 7'd65, 32'd5, 1'b1, mk_result(32'd0, 1'b0, ST_RANGE, 1));
    add_cmd(CMD_READ, 7'd0, 7'd1, 32'd0, 1'b1, mk_result(32'd0, 1'b0, ST_RANGE, 1));
    add_cmd(CMD_WRITE, 7'd1, 7'd1, 32'h80000000, 1'b0, '0);
    add_cmd(CMD_CONTAINS, 7'd0, 7'd0, 32'h80000000, 1'b1,
            mk_result(32'd0, 1'b1, ST_OK, 2));
    add_cmd(CMD_WRITE, 7'd1, 7'd1, 32'd0, 1'b0, '0);
    add_cmd(CMD_WRITE, 7'd2, 7'd2, 32'd0, 1'b0, '0);
    add_cmd(CMD_REDEF, 7'd0, 7'd0, 32'h7fffffff, 1'b1, mk_result(32'd0, 1'b0, ST_FULL, 1));
    add_cmd(CMD_REDEF, 7'd127, 7'd127, 32'd3, 1'b0, '0);
    add_cmd(CMD_READ, 7'd5, 7'd5, 32'd0, 1'b0, '0);
    add_cmd(CMD_WRITE, 7'd64, 7'd64, 32'd3, 1'b0, '0);
    add_cfg(REG_NUM_ROWS, 7'd0);
    add_cmd(CMD_READ, 7'd1, 7'd1, 32'd0, 1'b1, mk_result(32'd0, 1'b0, ST_RANGE, 0));
    add_cfg(REG_NUM_ROWS, 7'd3);
    add_cfg(REG_NUM_COLS, 7'd2);
    add_cmd(CMD_WRITE, 7'd3, 7'd2, 32'd9, 1'b0, '0);
    add_cmd(CMD_WRITE, 7'd3, 7'd1, 32'd8, 1'b0, '0);
    add_cmd(CMD_WRITE, 7'd1, 7'd1, 32'd9, 1'b0, '0);
    add_cmd(CMD_REDEF, 7'd0, 7'd0, 32'd9, 1'b0, '0);
    add_cmd(CMD_READ, 7'd2, 7'd2, 32'd0, 1'b0, '0);
    add_cmd(CMD_CONTAINS, 7'd0, 7'd0, 32'd3, 1'b0, '0);
    add_cmd(CMD_WRITE, 7'd1, 7'd2, 32'hffffffff, 1'b0, '0);
    add_cmd(CMD_READ, 7'd3, 7'd1, 32'd0, 1'b0, '0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      s = directed_rows[i];
      if (s.kind == ROW_CFG) write_register(s.regsel, s.value[6:0]);
      else send_cmd(s.cmd, s.row, s.col, s.value, s.typed, s.exp);
    end

    // A 33x32 grid with 32 cells holding the new default fills the store exactly.
    write_register(REG_NUM_ROWS, 7'd33);
    write_register(REG_NUM_COLS, 7'd32);
    for (int c = 1; c <= 32; c++) send_checked(CMD_WRITE, 7'd1, c[6:0], 32'd5);
    send_checked(CMD_REDEF, 7'd0, 7'd0, 32'd5);
    send_checked(CMD_WRITE, 7'd1, 7'd7, 32'd9);
    send_checked(CMD_WRITE, 7'd33, 7'd32, 32'd11);
    send_checked(CMD_READ, 7'd33, 7'd32, 32'd0);
    send_checked(CMD_WRITE, 7'd33, 7'd32, 32'd5);
    send_checked(CMD_WRITE, 7'd1, 7'd7, 32'd9);

    random_phase(175);
    send_idle_pct = 49;
    recv_idle_pct = 37;
    random_phase(175);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_phase(170);

    while (pending_results.size() > 0) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b0;
    repeat (200) @(posedge clk_i);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: sparse_matrix_csr_store_unit.f
hw/rtl/smcsr_pkg.sv
hw/rtl/sparse_matrix_csr_store_unit.sv
test/sparse_matrix_csr_store_unit_tb.sv
